// ===== design/aavs_pkg.sv =====
// Package for the ADC average and reference scaler.
// Holds widths, constants, controller state codes and the lane status type.
// No dependencies.
`timescale 1ns / 1ps

package aavs_pkg;

   localparam int SAMPLE_BITS  = 12;
   localparam int MAX_AVERAGE  = 1024;
   localparam int NUM_LANES    = 5;
   localparam int SUM_W        = 22;
   localparam int CNT_W        = 11;
   localparam int DIV_W        = 28;
   localparam int DVSR_W       = 12;
   localparam int STEP_W       = 5;
   localparam int OUT_W        = 16;
   localparam int TEMP_W       = 12;

   // lane order follows the input item
   localparam int LANE_Y    = 0;
   localparam int LANE_X    = 1;
   localparam int LANE_BAT  = 2;
   localparam int LANE_TEMP = 3;
   localparam int LANE_REF  = 4;

   // register indexes
   localparam logic [1:0] REG_AVERAGE_COUNT = 2'd0;
   localparam logic [1:0] REG_REFERENCE_MV  = 2'd1;
   localparam logic [1:0] REG_BATTERY_SCALE = 2'd2;

   localparam logic [10:0] RESET_AVERAGE = 11'd100;
   localparam logic [10:0] RESET_REF_MV  = 11'd1210;
   localparam logic [11:0] RESET_BAT_SC  = 12'd1853;

   localparam logic [11:0] FULL_SCALE    = 12'd4095;
   localparam logic [DIV_W-1:0] TEMP_OFFSET = 28'd7600;
   localparam logic [OUT_W-1:0] MV_MAX   = 16'hFFFF;

   // divide by the slope of 25 as a multiply by ceil(2^21 / 25) and a shift;
   // exact for magnitudes below 2^16
   localparam logic [16:0] TEMP_RECIP    = 17'd83887;
   localparam int          TEMP_RECIP_SH = 21;
   // largest magnitude that does not exceed the upper temperature clamp
   localparam logic [DIV_W-1:0] TEMP_SAT_MAG = 28'd50574;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_AVG   = 4'b0010,
      ST_SCALE = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   typedef struct packed {
      logic             busy;
      logic [DIV_W-1:0] quotient;
   } lane_stat_type;

endpackage

// ===== design/aavs_lane.sv =====
// One lane: a restoring divider that produces one quotient bit a cycle.
// Depends on aavs_pkg.
`timescale 1ns / 1ps

module aavs_lane (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [aavs_pkg::DIV_W-1:0]    numerator,
   input  logic [aavs_pkg::DVSR_W-1:0]   divisor,
   output aavs_pkg::lane_stat_type       stat
);
   import aavs_pkg::*;

   logic                busy_ff, busy_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [DIV_W-1:0]    quo_ff, quo_in;
   logic [DVSR_W-1:0]   rem_ff, rem_in;
   logic [DVSR_W-1:0]   dvsr_ff, dvsr_in;
   logic [DVSR_W:0]     trial;
   logic                fits;

   // shift in the next numerator bit and try a subtract
   assign trial = {rem_ff, quo_ff[DIV_W-1]};
   assign fits  = trial >= {1'b0, dvsr_ff};

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         quo_in  = numerator;
         rem_in  = '0;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         quo_in  = {quo_ff[DIV_W-2:0], fits};
         rem_in  = fits ? DVSR_W'(trial - {1'b0, dvsr_ff}) : trial[DVSR_W-1:0];
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(DIV_W - 1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      step_ff <= step_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign stat.busy     = busy_ff;
   assign stat.quotient = quo_ff;

endmodule

// ===== design/aavs_merge.sv =====
// Merging stage: saturates the lane quotients, forms the temperature and
// holds the result item until taken. Depends on aavs_pkg.
`timescale 1ns / 1ps

module aavs_merge (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          load,
   input  logic                          fault,
   input  logic                          temp_neg,
   input  logic [aavs_pkg::DIV_W-1:0]    temp_mag,
   input  aavs_pkg::lane_stat_type       lanes [aavs_pkg::NUM_LANES],
   output logic                          free,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [15:0]                   rsp_joystick_x_mv,
   output logic [15:0]                   rsp_joystick_y_mv,
   output logic [15:0]                   rsp_battery_mv,
   output logic [15:0]                   rsp_supply_mv,
   output logic signed [11:0]            rsp_temperature_c,
   output logic                          rsp_reference_fault
);
   import aavs_pkg::*;

   logic                     valid_ff, valid_in;
   logic [OUT_W-1:0]         x_ff, y_ff, bat_ff, sup_ff;
   logic signed [TEMP_W-1:0] temp_ff, temp_c;
   logic                     fault_ff;
   logic [OUT_W-1:0]         mag16;
   logic [32:0]              prod;
   logic [TEMP_W-1:0]        deg;
   logic                     above;

   function automatic logic [OUT_W-1:0] sat_mv(input logic [DIV_W-1:0] v);
      return (v > DIV_W'(MV_MAX)) ? MV_MAX : v[OUT_W-1:0];
   endfunction

   // degrees away from the base point by reciprocal multiply
   assign above = temp_mag > TEMP_SAT_MAG;
   assign mag16 = temp_mag[OUT_W-1:0];
   assign prod  = 33'(mag16) * 33'(TEMP_RECIP);
   assign deg   = prod[TEMP_RECIP_SH +: TEMP_W];

   // clamp the temperature at both ends
   always_comb begin
      if (!temp_neg) begin
         temp_c = above ? 12'sd2047 : $signed(12'd25 + deg);
      end else begin
         temp_c = (deg > 12'd304) ? -12'sd279 : $signed(12'd25 - deg);
      end
   end

   assign free     = !valid_ff || rsp_ready;
   assign valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         fault_ff <= fault;
         x_ff     <= fault ? '0 : sat_mv(lanes[LANE_X].quotient);
         y_ff     <= fault ? '0 : sat_mv(lanes[LANE_Y].quotient);
         bat_ff   <= fault ? '0 : sat_mv(lanes[LANE_BAT].quotient);
         sup_ff   <= fault ? '0 : sat_mv(lanes[LANE_REF].quotient);
         temp_ff  <= fault ? '0 : temp_c;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_joystick_x_mv   = x_ff;
   assign rsp_joystick_y_mv   = y_ff;
   assign rsp_battery_mv      = bat_ff;
   assign rsp_supply_mv       = sup_ff;
   assign rsp_temperature_c   = temp_ff;
   assign rsp_reference_fault = fault_ff;

endmodule

// ===== design/adc_average_vref_scaler_core.sv =====
// ADC scan averager with internal-reference ratiometric scaling.
// Each req item is one five-channel 12-bit scan; every scan is added into
// per-channel sums. The scan that completes an average (average_count scans,
// 0 acting as 1, capped at 1024) yields one rsp item; other scans yield none.
// Accepting a scan that does not complete an average keeps req_ready high.
// A completing scan starts five divider lanes that run 28 steps for the
// averages and 28 more for the reference scaling; the temperature slope
// is applied by a reciprocal multiply as the result forms. Once the output
// register is free, the result is loaded into it after the averaging pass,
// the scaling pass and the temperature distance register (after the
// averaging pass alone for a zero reference); req_ready is low meanwhile.
// A zero averaged reference skips the scaling and gives a fault item.
// If rsp is stalled, the block accepts scans until the next average
// completes, then waits for the output register to empty.
// Reset clears the sums and the scan count, empties the output register, and sets
// the registers to 100 scans, 1210 mV and battery scale 1853.
// csr writes take effect at once; write only while no item is in flight.
`timescale 1ns / 1ps

module adc_average_vref_scaler_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [11:0]         csr_wdata,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [11:0]         req_joystick_y_raw,
   input  logic [11:0]         req_joystick_x_raw,
   input  logic [11:0]         req_battery_raw,
   input  logic [11:0]         req_temperature_raw,
   input  logic [11:0]         req_reference_raw,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [15:0]         rsp_joystick_x_mv,
   output logic [15:0]         rsp_joystick_y_mv,
   output logic [15:0]         rsp_battery_mv,
   output logic [15:0]         rsp_supply_mv,
   output logic signed [11:0]  rsp_temperature_c,
   output logic                rsp_reference_fault
);
   import aavs_pkg::*;

   state_type         state_ff, state_in;
   logic [10:0]       avg_cnt_ff;
   logic [10:0]       ref_mv_ff;
   logic [11:0]       bat_sc_ff;
   logic [SUM_W-1:0]  sum_ff [NUM_LANES];
   logic [SUM_W-1:0]  sum_in [NUM_LANES];
   logic [CNT_W-1:0]  count_ff, count_in, count_next, target;
   logic [SAMPLE_BITS-1:0] sample [NUM_LANES];
   logic              fault_ff, fault_in;
   logic              neg_ff, neg_in;
   logic [DIV_W-1:0]  mag_ff, mag_in;
   logic              accept, complete, load, free;
   logic [NUM_LANES-1:0] start;
   logic [DIV_W-1:0]  num [NUM_LANES];
   logic [DVSR_W-1:0] dvsr [NUM_LANES];
   lane_stat_type     stat [NUM_LANES];
   logic [SAMPLE_BITS-1:0] q [NUM_LANES];
   logic [14:0]       ref_x10;
   logic [DIV_W-1:0]  t10;

   assign sample[LANE_Y]    = req_joystick_y_raw;
   assign sample[LANE_X]    = req_joystick_x_raw;
   assign sample[LANE_BAT]  = req_battery_raw;
   assign sample[LANE_TEMP] = req_temperature_raw;
   assign sample[LANE_REF]  = req_reference_raw;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;

   // clamp the average length
   always_comb begin
      if (avg_cnt_ff == '0) begin
         target = CNT_W'(1);
      end else if (avg_cnt_ff > CNT_W'(MAX_AVERAGE)) begin
         target = CNT_W'(MAX_AVERAGE);
      end else begin
         target = avg_cnt_ff;
      end
   end
   assign count_next = count_ff + 1'b1;
   assign complete   = count_next >= target;

   // averaged values, reduced to sample width
   always_comb begin
      for (int i = 0; i < NUM_LANES; i++) begin
         q[i] = stat[i].quotient[SAMPLE_BITS-1:0];
      end
   end
   assign ref_x10 = {1'b0, ref_mv_ff, 3'b000} + {3'b000, ref_mv_ff, 1'b0};
   assign t10     = stat[LANE_TEMP].quotient;

   // sequence the lanes through averaging and scaling
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      fault_in = fault_ff;
      neg_in   = neg_ff;
      mag_in   = mag_ff;
      load     = 1'b0;
      start    = '0;
      for (int i = 0; i < NUM_LANES; i++) begin
         sum_in[i] = sum_ff[i];
         num[i]    = DIV_W'(sum_ff[i] + SUM_W'(sample[i]));
         dvsr[i]   = DVSR_W'(count_next);
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (complete) begin
                  start    = '1;
                  count_in = '0;
                  for (int i = 0; i < NUM_LANES; i++) begin
                     sum_in[i] = '0;
                  end
                  state_in = ST_AVG;
               end else begin
                  count_in = count_next;
                  for (int i = 0; i < NUM_LANES; i++) begin
                     sum_in[i] = sum_ff[i] + SUM_W'(sample[i]);
                  end
               end
            end
         end
         ST_AVG: begin
            num[LANE_Y]    = DIV_W'(q[LANE_Y] * ref_mv_ff);
            num[LANE_X]    = DIV_W'(q[LANE_X] * ref_mv_ff);
            num[LANE_BAT]  = DIV_W'(q[LANE_BAT] * bat_sc_ff);
            num[LANE_TEMP] = DIV_W'(q[LANE_TEMP] * ref_x10);
            num[LANE_REF]  = DIV_W'(FULL_SCALE * ref_mv_ff);
            for (int i = 0; i < NUM_LANES; i++) begin
               dvsr[i] = q[LANE_REF];
            end
            if (!stat[LANE_REF].busy) begin
               if (q[LANE_REF] == '0) begin
                  fault_in = 1'b1;
                  state_in = ST_DONE;
               end else begin
                  fault_in = 1'b0;
                  start    = '1;
                  state_in = ST_SCALE;
               end
            end
         end
         ST_SCALE: begin
            // hold the distance from the temperature offset and its sign
            if (!stat[LANE_TEMP].busy) begin
               neg_in   = t10 < TEMP_OFFSET;
               mag_in   = (t10 < TEMP_OFFSET) ? TEMP_OFFSET - t10 : t10 - TEMP_OFFSET;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // hold state, sums and registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         avg_cnt_ff <= RESET_AVERAGE;
         ref_mv_ff  <= RESET_REF_MV;
         bat_sc_ff  <= RESET_BAT_SC;
         for (int i = 0; i < NUM_LANES; i++) begin
            sum_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         for (int i = 0; i < NUM_LANES; i++) begin
            sum_ff[i] <= sum_in[i];
         end
         if (csr_wr_en) begin
            case (csr_index)
               REG_AVERAGE_COUNT: avg_cnt_ff <= csr_wdata[10:0];
               REG_REFERENCE_MV:  ref_mv_ff  <= csr_wdata[10:0];
               REG_BATTERY_SCALE: bat_sc_ff  <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
      fault_ff <= fault_in;
      neg_ff   <= neg_in;
      mag_ff   <= mag_in;
   end

   // five divider lanes side by side
   for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
      aavs_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .start     (start[g]),
         .numerator (num[g]),
         .divisor   (dvsr[g]),
         .stat      (stat[g])
      );
   end

   aavs_merge u_merge (
      .clock               (clock),
      .reset               (reset),
      .load                (load),
      .fault               (fault_ff),
      .temp_neg            (neg_ff),
      .temp_mag            (mag_ff),
      .lanes               (stat),
      .free                (free),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_joystick_x_mv   (rsp_joystick_x_mv),
      .rsp_joystick_y_mv   (rsp_joystick_y_mv),
      .rsp_battery_mv      (rsp_battery_mv),
      .rsp_supply_mv       (rsp_supply_mv),
      .rsp_temperature_c   (rsp_temperature_c),
      .rsp_reference_fault (rsp_reference_fault)
   );

endmodule

// ===== verif/adc_average_vref_scaler_core_tb.sv =====
// Testbench for the ADC scan averager with reference scaling.
// Drives scans and register writes, predicts each averaged result and checks it.
// Depends on aavs_pkg and adc_average_vref_scaler_core.
`timescale 1ns / 1ps

module adc_average_vref_scaler_core_tb;
   import aavs_pkg::*;

   typedef struct {
      logic [15:0]        x_mv;
      logic [15:0]        y_mv;
      logic [15:0]        bat_mv;
      logic [15:0]        sup_mv;
      logic signed [11:0] temp_c;
      logic               fault;
   } reading_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = REG_AVERAGE_COUNT;
   logic [11:0] csr_wdata = '0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [11:0] req_joystick_y_raw = '0;
   logic [11:0] req_joystick_x_raw = '0;
   logic [11:0] req_battery_raw = '0;
   logic [11:0] req_temperature_raw = '0;
   logic [11:0] req_reference_raw = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_joystick_x_mv, rsp_joystick_y_mv, rsp_battery_mv, rsp_supply_mv;
   logic signed [11:0] rsp_temperature_c;
   logic        rsp_reference_fault;

   adc_average_vref_scaler_core DUT (.*);

   // predictor state
   logic [10:0] avg_len_reg;
   logic [10:0] ref_mv_reg;
   logic [11:0] bat_scale_reg;
   logic [21:0] lane_sum [5];
   logic [10:0] scan_count;

   reading_type expected_readings [$];
   int          mismatches = 0;
   int          cycle_count = 0;
   int          hold_off = 0;
   int          rsp_wait = 0;

   localparam int CYCLE_LIMIT = 3000000;

   initial begin
      forever #5 clock = ~clock;
   end

   // timeout
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("adc_average_vref_scaler_core_tb: done, errors");
         $finish;
      end
   end

   function automatic logic [15:0] sat16(logic [63:0] v);
      return (v > 64'd65535) ? 16'hFFFF : v[15:0];
   endfunction

   // accumulate one scan; push a reading when an average completes
   function automatic void average_scan(logic [11:0] y, logic [11:0] x, logic [11:0] b,
                                        logic [11:0] t, logic [11:0] r);
      logic [10:0] target;
      logic [63:0] avg [5];
      logic [63:0] v, rm, t10, mag;
      longint      temp;
      reading_type rd;
      lane_sum[0] += y;
      lane_sum[1] += x;
      lane_sum[2] += b;
      lane_sum[3] += t;
      lane_sum[4] += r;
      scan_count++;
      target = avg_len_reg;
      if (target == 0) target = 11'd1;
      if (target > MAX_AVERAGE) target = 11'(MAX_AVERAGE);
      if (scan_count < target) return;
      for (int i = 0; i < 5; i++) begin
         avg[i] = 64'(lane_sum[i]) / 64'(scan_count);
         lane_sum[i] = '0;
      end
      scan_count = '0;
      v = avg[4];
      rd = '{default: '0};
      if (v == 0) begin
         rd.fault = 1'b1;
      end else begin
         rm = 64'(ref_mv_reg);
         rd.x_mv = sat16(avg[1] * rm / v);
         rd.y_mv = sat16(avg[0] * rm / v);
         rd.bat_mv = sat16(avg[2] * 64'(bat_scale_reg) / v);
         rd.sup_mv = sat16(64'd4095 * rm / v);
         t10 = avg[3] * rm * 10 / v;
         if (t10 >= 7600) begin
            mag = (t10 - 7600) / 25;
            temp = (mag > 2022) ? 2047 : 25 + longint'(mag);
         end else begin
            mag = (7600 - t10) / 25;
            temp = 25 - longint'(mag);
         end
         if (temp < -279) temp = -279;
         if (temp > 2047) temp = 2047;
         rd.temp_c = 12'(temp);
      end
      expected_readings.push_back(rd);
   endfunction

   // receiver: pause for a random draw after each item, long hold-off on request
   always @(negedge clock) begin
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_wait > 0) begin
         rsp_wait <= rsp_wait - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // check each reading against the oldest expectation
   always @(posedge clock) begin
      reading_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_wait <= $urandom_range(0, 8);
         if (expected_readings.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected reading at cycle %0d", cycle_count);
         end else begin
            e = expected_readings.pop_front();
            if (rsp_joystick_x_mv !== e.x_mv || rsp_joystick_y_mv !== e.y_mv ||
                rsp_battery_mv !== e.bat_mv || rsp_supply_mv !== e.sup_mv ||
                rsp_temperature_c !== e.temp_c || rsp_reference_fault !== e.fault) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: exp x%0d y%0d b%0d s%0d t%0d f%0d got x%0d y%0d b%0d s%0d t%0d f%0d",
                     e.x_mv, e.y_mv, e.bat_mv, e.sup_mv, e.temp_c, e.fault,
                     rsp_joystick_x_mv, rsp_joystick_y_mv, rsp_battery_mv,
                     rsp_supply_mv, rsp_temperature_c, rsp_reference_fault);
            end
         end
      end
   end

   // send one scan after a random gap; hold until accepted
   task automatic send_scan(logic [11:0] y, logic [11:0] x, logic [11:0] b,
                            logic [11:0] t, logic [11:0] r, bit no_gap = 0);
      int gap;
      gap = no_gap ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_joystick_y_raw <= y;
      req_joystick_x_raw <= x;
      req_battery_raw <= b;
      req_temperature_raw <= t;
      req_reference_raw <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      average_scan(y, x, b, t, r);
      @(negedge clock);
   endtask

   task automatic send_random_scan(int ref_low);
      send_scan(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                12'($urandom_range(ref_low, 4095)), $urandom_range(0, 3) == 0);
   endtask

   // drop valid, wait for all readings, then let a completing divide settle
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(negedge clock);
      repeat (120) @(negedge clock);
   endtask

   task automatic write_reg(logic [1:0] idx, logic [11:0] val);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         REG_AVERAGE_COUNT: avg_len_reg = val[10:0];
         REG_REFERENCE_MV:  ref_mv_reg = val[10:0];
         REG_BATTERY_SCALE: bat_scale_reg = val;
         default: ;
      endcase
   endtask

   // extremes with single-scan averages, zero reference, tiny reference and an oversized length
   task automatic test_directed_extremes;
      write_reg(REG_AVERAGE_COUNT, 12'd1);
      write_reg(REG_REFERENCE_MV, 12'd1400);
      write_reg(REG_BATTERY_SCALE, 12'd4095);
      send_scan(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF);
      send_scan(12'h000, 12'h000, 12'h000, 12'h000, 12'hFFF);
      send_scan(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h000);
      send_scan(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 12'h001);
      send_scan(12'hAAA, 12'h555, 12'hAAA, 12'h555, 12'h5A5);
      send_scan(12'h555, 12'hAAA, 12'h555, 12'hAAA, 12'hA5A);
      send_scan(12'd0, 12'd0, 12'd0, 12'd1000, 12'd1500);
      send_scan(12'd0, 12'd0, 12'd0, 12'd1, 12'd4095);
      drain();
      write_reg(REG_AVERAGE_COUNT, 12'd0);
      write_reg(REG_BATTERY_SCALE, 12'd0);
      write_reg(REG_REFERENCE_MV, 12'd1000);
      send_scan(12'd100, 12'd200, 12'd300, 12'd900, 12'd1500);
      send_scan(12'd4095, 12'd0, 12'd4095, 12'd4095, 12'd2);
      drain();
      // oversized length clamps to the maximum
      write_reg(REG_AVERAGE_COUNT, 12'd2047);
      write_reg(REG_REFERENCE_MV, 12'd2047);
      repeat (1024) send_scan(12'($urandom_range(0, 4095)), 12'hFFF, 12'hFFF,
                              12'hFFF, 12'd1, 1);
      drain();
   endtask

   // lower the length below the scans already summed
   task automatic test_length_lowered;
      write_reg(REG_AVERAGE_COUNT, 12'd10);
      write_reg(REG_REFERENCE_MV, 12'd1210);
      repeat (6) send_random_scan(1);
      drain();
      write_reg(REG_AVERAGE_COUNT, 12'd3);
      send_random_scan(1);
      drain();
      // zero reference averaged over several scans
      write_reg(REG_AVERAGE_COUNT, 12'd4);
      repeat (4) send_scan(12'd7, 12'd7, 12'd7, 12'd7, 12'd0);
      drain();
   endtask

   // random scans over several settings
   task automatic test_random_settings;
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(REG_AVERAGE_COUNT, 12'($urandom_range(1, 6)));
         write_reg(REG_REFERENCE_MV, 12'($urandom_range(1000, 1400)));
         write_reg(REG_BATTERY_SCALE, 12'($urandom_range(0, 4095)));
         repeat (70) send_random_scan(($urandom_range(0, 9) == 0) ? 0 : 1);
         drain();
      end
   endtask

   // stall the receiver long while scans keep coming
   task automatic test_output_backpressure;
      write_reg(REG_AVERAGE_COUNT, 12'd1);
      write_reg(REG_REFERENCE_MV, 12'd1210);
      write_reg(REG_BATTERY_SCALE, 12'd1853);
      @(negedge clock);
      hold_off <= 600;
      repeat (12) send_random_scan(1);
      drain();
      // reset-style defaults in a final short run
      write_reg(REG_AVERAGE_COUNT, 12'd100);
      repeat (200) send_random_scan(1);
      drain();
   endtask

   initial begin
      avg_len_reg = RESET_AVERAGE;
      ref_mv_reg = RESET_REF_MV;
      bat_scale_reg = RESET_BAT_SC;
      foreach (lane_sum[i]) lane_sum[i] = '0;
      scan_count = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed_extremes();
      test_length_lowered();
      test_random_settings();
      test_output_backpressure();
      if (mismatches == 0) begin
         $display("adc_average_vref_scaler_core_tb: done, clean");
      end else begin
         $display("adc_average_vref_scaler_core_tb: done, errors");
      end
      $finish;
   end

endmodule

// ===== files.f =====
design/aavs_pkg.sv
design/aavs_lane.sv
design/aavs_merge.sv
design/adc_average_vref_scaler_core.sv
verif/adc_average_vref_scaler_core_tb.sv
